/* rtl/ffd_pkg.sv */
`timescale 1ns / 1ps

package ffd_pkg;

  localparam int unsigned MaxPayload     = 64;
  localparam int unsigned FeedbackLength = 32;
  localparam int unsigned StoreAw        = $clog2(FeedbackLength);

  localparam logic [7:0]  SyncA   = 8'hA5;
  localparam logic [7:0]  SyncB   = 8'h5A;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef enum logic [1:0] {
    StFeedback = 2'd0,
    StOther    = 2'd1,
    StCrcErr   = 2'd2,
    StOversize = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic        [31:0] sequence_number;
    logic        [31:0] timestamp_us;
    logic signed [31:0] encoder_count;
    logic signed [31:0] speed_tenth_rpm;
    logic        [15:0] hall_and_flags;
    logic signed [15:0] current_a_ma;
    logic signed [15:0] current_b_ma;
    logic signed [15:0] current_c_ma;
    logic        [15:0] bus_voltage_mv;
    logic signed [15:0] floating_voltage_mv;
    logic signed [31:0] torque_micro;
  } res_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/ffd_if.sv */
`timescale 1ns / 1ps

interface ffd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] feedback_type;

  modport source (output valid, output feedback_type, input ready);
  modport sink (input valid, input feedback_type, output ready);
endinterface

interface ffd_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [31:0] sequence_number;
  logic        [31:0] timestamp_us;
  logic signed [31:0] encoder_count;
  logic signed [31:0] speed_tenth_rpm;
  logic        [15:0] hall_and_flags;
  logic signed [15:0] current_a_ma;
  logic signed [15:0] current_b_ma;
  logic signed [15:0] current_c_ma;
  logic        [15:0] bus_voltage_mv;
  logic signed [15:0] floating_voltage_mv;
  logic signed [31:0] torque_micro;

  modport source (
    output valid, output status, output sequence_number, output timestamp_us,
    output encoder_count, output speed_tenth_rpm, output hall_and_flags,
    output current_a_ma, output current_b_ma, output current_c_ma,
    output bus_voltage_mv, output floating_voltage_mv, output torque_micro,
    input ready
  );
  modport sink (
    input valid, input status, input sequence_number, input timestamp_us,
    input encoder_count, input speed_tenth_rpm, input hall_and_flags,
    input current_a_ma, input current_b_ma, input current_c_ma,
    input bus_voltage_mv, input floating_voltage_mv, input torque_micro,
    output ready
  );
endinterface

/* rtl/ffd_in_stage.sv */
`timescale 1ns / 1ps

module ffd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffd_rx_if.sink     rx_i,
  input  logic       advance_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;
endmodule

/* rtl/ffd_parser.sv */
`timescale 1ns / 1ps

module ffd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  input  logic [7:0]    feedback_type_i,
  input  logic          slot_free_i,
  output logic          advance_o,
  output logic          produce_o,
  output ffd_pkg::res_t res_o
);
  import ffd_pkg::*;

  typedef enum logic [2:0] {
    PhHunt0 = 3'd0,
    PhHunt1 = 3'd1,
    PhType  = 3'd2,
    PhLen   = 3'd3,
    PhPay   = 3'd4,
    PhCrc0  = 3'd5,
    PhCrc1  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  idx_inc;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [15:0] rcrc_full;
  logic [15:0] crc_in;
  logic [15:0] crc_out;
  logic        store_we;
  logic [7:0]  store_q [FeedbackLength];
  logic        produce;
  res_t        res;

  assign idx_inc   = idx_q + 8'd1;
  assign crc_in    = (phase_q == PhType) ? CrcInit : crc_q;
  assign crc_out   = crc_byte(crc_in, byte_i);
  assign rcrc_full = {byte_i, rcrc_q[7:0]};

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    rcrc_d   = rcrc_q;
    store_we = 1'b0;
    produce  = 1'b0;
    res      = '0;
    unique case (phase_q)
      PhHunt1: begin
        if (byte_i == SyncB) begin
          phase_d = PhType;
        end else if (byte_i == SyncA) begin
          phase_d = PhHunt1;
        end else begin
          phase_d = PhHunt0;
        end
      end
      PhType: begin
        type_d  = byte_i;
        crc_d   = crc_out;
        phase_d = PhLen;
      end
      PhLen: begin
        len_d = byte_i;
        idx_d = 8'd0;
        crc_d = crc_out;
        if (byte_i > 8'(MaxPayload)) begin
          phase_d    = PhHunt0;
          produce    = 1'b1;
          res.status = StOversize;
        end else if (byte_i == 8'd0) begin
          phase_d = PhCrc0;
        end else begin
          phase_d = PhPay;
        end
      end
      PhPay: begin
        store_we = (idx_q < 8'(FeedbackLength));
        crc_d    = crc_out;
        idx_d    = idx_inc;
        if (idx_inc >= len_q) begin
          phase_d = PhCrc0;
        end
      end
      PhCrc0: begin
        rcrc_d  = {8'd0, byte_i};
        phase_d = PhCrc1;
      end
      PhCrc1: begin
        rcrc_d  = rcrc_full;
        phase_d = PhHunt0;
        produce = 1'b1;
        priority if (crc_q != rcrc_full) begin
          res.status = StCrcErr;
        end else if (type_q != feedback_type_i || len_q != 8'(FeedbackLength)) begin
          res.status = StOther;
        end else begin
          res.status              = StFeedback;
          res.sequence_number     = {store_q[3], store_q[2], store_q[1], store_q[0]};
          res.timestamp_us        = {store_q[7], store_q[6], store_q[5], store_q[4]};
          res.encoder_count       = {store_q[11], store_q[10], store_q[9], store_q[8]};
          res.speed_tenth_rpm     = {store_q[15], store_q[14], store_q[13], store_q[12]};
          res.hall_and_flags      = {store_q[17], store_q[16]};
          res.current_a_ma        = {store_q[19], store_q[18]};
          res.current_b_ma        = {store_q[21], store_q[20]};
          res.current_c_ma        = {store_q[23], store_q[22]};
          res.bus_voltage_mv      = {store_q[25], store_q[24]};
          res.floating_voltage_mv = {store_q[27], store_q[26]};
          res.torque_micro        = {store_q[31], store_q[30], store_q[29], store_q[28]};
        end
      end
      default: begin
        phase_d = (byte_i == SyncA) ? PhHunt1 : PhHunt0;
      end
    endcase
  end

  assign advance_o = byte_valid_i && (!produce || slot_free_i);
  assign produce_o = produce;
  assign res_o     = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt0;
      type_q  <= 8'd0;
      len_q   <= 8'd0;
      idx_q   <= 8'd0;
      crc_q   <= CrcInit;
      rcrc_q  <= 16'd0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && store_we) begin
      store_q[idx_q[StoreAw-1:0]] <= byte_i;
    end
  end
endmodule

/* rtl/ffd_out_stage.sv */
`timescale 1ns / 1ps

module ffd_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ffd_pkg::res_t res_i,
  output logic          slot_free_o,
  ffd_res_if.source     res_o
);
  import ffd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign slot_free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid               = valid_q;
  assign res_o.status              = res_q.status;
  assign res_o.sequence_number     = res_q.sequence_number;
  assign res_o.timestamp_us        = res_q.timestamp_us;
  assign res_o.encoder_count       = res_q.encoder_count;
  assign res_o.speed_tenth_rpm     = res_q.speed_tenth_rpm;
  assign res_o.hall_and_flags      = res_q.hall_and_flags;
  assign res_o.current_a_ma        = res_q.current_a_ma;
  assign res_o.current_b_ma        = res_q.current_b_ma;
  assign res_o.current_c_ma        = res_q.current_c_ma;
  assign res_o.bus_voltage_mv      = res_q.bus_voltage_mv;
  assign res_o.floating_voltage_mv = res_q.floating_voltage_mv;
  assign res_o.torque_micro        = res_q.torque_micro;
endmodule

/* rtl/feedback_frame_deframer_crc16.sv */
`timescale 1ns / 1ps
// Frame deframer for a byte stream: hunts for sync A5 5A, then reads type,
// length, payload and a little-endian CRC-16/CCITT-FALSE over type, length
// and payload. Frames of the configured feedback type and 32 payload bytes
// are unpacked into raw little-endian fields.
// Channels: rx_i takes one received byte per transaction; res_o gives one
// result per frame end (status 0..2) or per length byte above 64 (status 3),
// with all data fields zero when status is non-zero; cfg_i writes the
// feedback type and is always ready.
// Path: a byte accepted into the input register is parsed there, and the
// same parser step loads its result into the output register. Throughput:
// one byte per cycle unless stalled (see Stall), set by the single pass of
// CRC update and parser step between the input and result registers.
// Reset: parser returns to the hunt, CRC to FFFF, feedback type to 1, and
// both channel registers empty. Payload storage is not cleared.
// Stall: while a result waits on res_o, bytes that produce no result keep
// flowing; a byte that would produce a second result holds in the input
// register and rx_i ready drops until the waiting result is taken.
module feedback_frame_deframer_crc16 (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffd_rx_if.sink    rx_i,
  ffd_cfg_if.sink   cfg_i,
  ffd_res_if.source res_o
);
  import ffd_pkg::*;

  logic       cfg_we;
  logic [7:0] feedback_type_q;
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;
  logic       produce;
  logic       slot_free;
  res_t       res;

  assign cfg_we      = cfg_i.valid;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feedback_type_q <= 8'd1;
    end else if (cfg_we) begin
      feedback_type_q <= cfg_i.feedback_type;
    end
  end

  ffd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .advance_i   (advance),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_q)
  );

  ffd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (byte_valid),
    .byte_i         (byte_q),
    .feedback_type_i(feedback_type_q),
    .slot_free_i    (slot_free),
    .advance_o      (advance),
    .produce_o      (produce),
    .res_o          (res)
  );

  ffd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && produce),
    .res_i      (res),
    .slot_free_o(slot_free),
    .res_o      (res_o)
  );
endmodule

/* rtl/ffd_checker.sv */
`timescale 1ns / 1ps

module ffd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_i,
  input logic        cfg_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] sequence_number_i,
  input logic [31:0] timestamp_us_i,
  input logic [31:0] encoder_count_i,
  input logic [31:0] speed_tenth_rpm_i,
  input logic [15:0] hall_and_flags_i,
  input logic [15:0] current_a_ma_i,
  input logic [15:0] current_b_ma_i,
  input logic [15:0] current_c_ma_i,
  input logic [15:0] bus_voltage_mv_i,
  input logic [15:0] floating_voltage_mv_i,
  input logic [31:0] torque_micro_i
);
  import ffd_pkg::*;

  logic data_zero;

  assign data_zero = (sequence_number_i == '0) && (timestamp_us_i == '0)
                  && (encoder_count_i == '0) && (speed_tenth_rpm_i == '0)
                  && (hall_and_flags_i == '0) && (current_a_ma_i == '0)
                  && (current_b_ma_i == '0) && (current_c_ma_i == '0)
                  && (bus_voltage_mv_i == '0) && (floating_voltage_mv_i == '0)
                  && (torque_micro_i == '0);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i))
    else $error("result dropped or changed while stalled");

  a_error_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != StFeedback |-> data_zero)
    else $error("non-feedback result carries data");

  a_rx_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> rx_ready_i)
    else $error("byte channel stalled with no result waiting");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel back-pressured");
endmodule

bind feedback_frame_deframer_crc16 ffd_checker u_ffd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .rx_ready_i           (rx_i.ready),
  .cfg_ready_i          (cfg_i.ready),
  .res_valid_i          (res_o.valid),
  .res_ready_i          (res_o.ready),
  .status_i             (res_o.status),
  .sequence_number_i    (res_o.sequence_number),
  .timestamp_us_i       (res_o.timestamp_us),
  .encoder_count_i      (res_o.encoder_count),
  .speed_tenth_rpm_i    (res_o.speed_tenth_rpm),
  .hall_and_flags_i     (res_o.hall_and_flags),
  .current_a_ma_i       (res_o.current_a_ma),
  .current_b_ma_i       (res_o.current_b_ma),
  .current_c_ma_i       (res_o.current_c_ma),
  .bus_voltage_mv_i     (res_o.bus_voltage_mv),
  .floating_voltage_mv_i(res_o.floating_voltage_mv),
  .torque_micro_i       (res_o.torque_micro)
);
